FILE: design/mac_pkg.sv
`default_nettype none

package mac_pkg;

  // Fixed field widths of the request and result items
  localparam int ADDR_FIELD_W = 48;
  localparam int SIZE_FIELD_W = 13;
  localparam int RANGE_SIZE_W = 32;
  localparam int MAX_FLUSH    = 16;
  localparam int FLUSH_CNT_W  = 4;

  typedef struct packed {
    logic                    kind;
    logic [ADDR_FIELD_W-1:0] access_address;
    logic [SIZE_FIELD_W-1:0] byte_count;
    logic [1:0]              access_kind;
  } mac_in_t;

  typedef struct packed {
    logic [ADDR_FIELD_W-1:0] range_start;
    logic [RANGE_SIZE_W-1:0] range_size;
    logic [1:0]              range_flags;
    logic [RANGE_SIZE_W-1:0] largest_size;
    logic                    table_empty;
    logic                    overflowed;
    logic                    last;
  } mac_out_t;

  // Request kinds
  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // Per-cycle command to one table cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_PREV,
    CELL_NEXT,
    CELL_KILL
  } mac_cell_op_t;

endpackage

`default_nettype wire

FILE: design/memory_access_range_coalescer.sv
// Memory access range coalescer.
// Input channel (in_valid/in_ready/in_data): an access request adds the
// byte range [access_address, access_address + byte_count) to a table of
// up to TABLE_DEPTH disjoint ranges kept in address order; zero-size
// accesses are ignored. A flush request streams every stored range, in
// address order, on the result channel (out_valid/out_ready/out_data),
// with last on the final one, then clears the table. An empty table
// gives one result with table_empty set. A full table drops a new
// non-merging access and sets the sticky overflowed flag.
// Flow: an access is compared across all cells, then the table is updated;
// a zero-size access is dropped at once. An access that merges k > 1 stored
// ranges adds a compaction step, the cells closing one gap per cycle by
// shifting toward the head. A flush request moves the sequencer to its flush
// state, which loads the first result from the head cell into the output
// register, then one per cycle while the receiver takes them; at most 16 results per flush.
// in_ready drops while an item is in progress. A stalled receiver holds
// the output register and freezes the flush shift.
// Reset (synchronous, rst_n low) empties the table and clears the
// largest-size and overflow records.
`default_nettype none

module memory_access_range_coalescer #(
  parameter int TABLE_DEPTH  = 16,
  parameter int ADDRESS_BITS = 48
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mac_pkg::mac_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mac_pkg::mac_out_t     out_data
);

  import mac_pkg::*;

  localparam int AW = ADDRESS_BITS;
  localparam int D  = TABLE_DEPTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_COMPACT,
    ST_FLUSH
  } state_t;

  state_t                 state_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  mac_out_t               out_data_r;
  logic [FLUSH_CNT_W-1:0] cnt_r;
  logic [RANGE_SIZE_W-1:0] largest_r;
  logic                   ovf_r;

  logic [AW-1:0] lo_r;
  logic [AW:0]   hi_r;
  logic [1:0]    fl_r;
  logic [D-1:0]  hit_r, first_r, less_r;
  logic          any_r, multi_r;

  // Cell row
  mac_cell_op_t  op [D];
  logic          c_valid [D];
  logic [AW-1:0] c_start [D];
  logic [AW:0]   c_end [D];
  logic [1:0]    c_flags [D];
  logic [D-1:0]  hit, less, gap;

  logic [63:0]   addr_wide;
  logic [AW-1:0] probe_lo;
  logic [AW:0]   probe_hi;

  assign addr_wide = 64'(in_data.access_address);
  assign probe_lo  = addr_wide[AW-1:0];
  assign probe_hi  = {1'b0, probe_lo} + (AW+1)'(in_data.byte_count);

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic          p_valid, n_valid, g_in;
    logic [AW-1:0] p_start, n_start;
    logic [AW:0]   p_end, n_end;
    logic [1:0]    p_flags, n_flags;

    if (i == 0) begin : g_head
      assign p_valid = 1'b0;
      assign p_start = '0;
      assign p_end   = '0;
      assign p_flags = '0;
      assign g_in    = 1'b0;
    end else begin : g_body
      assign p_valid = c_valid[i-1];
      assign p_start = c_start[i-1];
      assign p_end   = c_end[i-1];
      assign p_flags = c_flags[i-1];
      assign g_in    = gap[i-1];
    end

    if (i == D-1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_start = '0;
      assign n_end   = '0;
      assign n_flags = '0;
    end else begin : g_inner
      assign n_valid = c_valid[i+1];
      assign n_start = c_start[i+1];
      assign n_end   = c_end[i+1];
      assign n_flags = c_flags[i+1];
    end

    mac_cell #(.AW(AW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op[i]),
      .new_start  (lo_r),
      .new_end    (hi_r),
      .new_flags  (fl_r),
      .prev_valid (p_valid),
      .prev_start (p_start),
      .prev_end   (p_end),
      .prev_flags (p_flags),
      .next_valid (n_valid),
      .next_start (n_start),
      .next_end   (n_end),
      .next_flags (n_flags),
      .probe_lo   (probe_lo),
      .probe_hi   (probe_hi),
      .gap_in     (g_in),
      .valid      (c_valid[i]),
      .start      (c_start[i]),
      .end_addr   (c_end[i]),
      .flags      (c_flags[i]),
      .hit        (hit[i]),
      .less       (less[i]),
      .gap_out    (gap[i])
    );
  end

  // Pick the edges of the run of hit cells and fold them into the new range
  logic [D-1:0]  first;
  logic [AW-1:0] sel_start, m_lo;
  logic [AW:0]   sel_end, m_hi;
  logic [1:0]    sel_flags;
  logic          any_hit;

  always_comb begin
    sel_start = '0;
    sel_end   = '0;
    sel_flags = '0;
    for (int i = 0; i < D; i++) begin
      first[i] = hit[i] && ((i == 0) || !hit[(i == 0) ? 0 : i-1]);
      if (first[i]) sel_start = sel_start | c_start[i];
      if (hit[i] && ((i == D-1) || !hit[(i == D-1) ? i : i+1]))
        sel_end = sel_end | c_end[i];
      if (hit[i]) sel_flags = sel_flags | c_flags[i];
    end
    any_hit = |hit;
    m_lo    = (any_hit && (sel_start < probe_lo)) ? sel_start : probe_lo;
    m_hi    = (any_hit && (sel_end > probe_hi)) ? sel_end : probe_hi;
  end

  // Size of the merged range and of the head cell, saturated
  logic [AW:0]             m_diff, h_diff;
  logic [RANGE_SIZE_W-1:0] m_size, h_size;

  assign m_diff = hi_r - {1'b0, lo_r};
  assign h_diff = c_end[0] - {1'b0, c_start[0]};
  assign m_size = (|m_diff[AW:RANGE_SIZE_W]) ? '1 : m_diff[RANGE_SIZE_W-1:0];
  assign h_size = (|h_diff[AW:RANGE_SIZE_W]) ? '1 : h_diff[RANGE_SIZE_W-1:0];

  logic full, bubble, out_free, flush_last;
  logic [63:0] head_wide;

  assign full       = !any_r && c_valid[D-1];
  assign out_free   = !out_valid_r || out_ready;
  assign flush_last = !c_valid[1] || (cnt_r == FLUSH_CNT_W'(MAX_FLUSH - 1));
  assign head_wide  = 64'(c_start[0]);

  always_comb begin
    bubble = 1'b0;
    for (int i = 0; i < D-1; i++) begin
      if (!c_valid[i] && c_valid[i+1]) bubble = 1'b1;
    end
  end

  // Per-cell commands
  always_comb begin
    for (int i = 0; i < D; i++) begin
      op[i] = CELL_HOLD;
      case (state_r)
        ST_MERGE: begin
          if (any_r) begin
            if (first_r[i])    op[i] = CELL_LOAD;
            else if (hit_r[i]) op[i] = CELL_KILL;
          end else if (!full) begin
            if (!less_r[i] && ((i == 0) || less_r[(i == 0) ? 0 : i-1]))
              op[i] = CELL_LOAD;
            else if ((i > 0) && !less_r[(i == 0) ? 0 : i-1])
              op[i] = CELL_PREV;
          end
        end
        ST_COMPACT: begin
          if (bubble && gap[i]) op[i] = CELL_NEXT;
        end
        ST_FLUSH: begin
          if (out_free) begin
            if ((cnt_r == '0 && !c_valid[0]) || flush_last) op[i] = CELL_KILL;
            else                                            op[i] = CELL_NEXT;
          end
        end
        default: op[i] = CELL_HOLD;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Load a result whenever the flush has room, else drop it once taken
  assign out_valid_nxt = ((state_r == ST_FLUSH) && out_free) ? 1'b1
                                                              : (out_valid_r && !out_ready);

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      largest_r   <= '0;
      ovf_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.kind == KIND_FLUSH) begin
              cnt_r   <= '0;
              state_r <= ST_FLUSH;
            end else if (in_data.byte_count != '0) begin
              lo_r    <= m_lo;
              hi_r    <= m_hi;
              fl_r    <= in_data.access_kind | sel_flags;
              hit_r   <= hit;
              first_r <= first;
              less_r  <= less;
              any_r   <= any_hit;
              multi_r <= |(hit & ~first);
              state_r <= ST_MERGE;
            end
          end
        end
        ST_MERGE: begin
          if (full) begin
            ovf_r <= 1'b1;
          end else if (m_size > largest_r) begin
            largest_r <= m_size;
          end
          state_r <= (any_r && multi_r) ? ST_COMPACT : ST_IDLE;
        end
        ST_COMPACT: begin
          if (!bubble) state_r <= ST_IDLE;
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_data_r.largest_size  <= largest_r;
            out_data_r.overflowed    <= ovf_r;
            if (cnt_r == '0 && !c_valid[0]) begin
              out_data_r.range_start <= '0;
              out_data_r.range_size  <= '0;
              out_data_r.range_flags <= '0;
              out_data_r.table_empty <= 1'b1;
              out_data_r.last        <= 1'b1;
            end else begin
              out_data_r.range_start <= head_wide[ADDR_FIELD_W-1:0];
              out_data_r.range_size  <= h_size;
              out_data_r.range_flags <= c_flags[0];
              out_data_r.table_empty <= 1'b0;
              out_data_r.last        <= flush_last;
            end
            cnt_r <= cnt_r + FLUSH_CNT_W'(1);
            if ((cnt_r == '0 && !c_valid[0]) || flush_last) begin
              largest_r <= '0;
              ovf_r     <= 1'b0;
              state_r   <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/mac_cell.sv
`default_nettype none

module mac_cell #(
  parameter int AW = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mac_pkg::mac_cell_op_t op,
  input  wire logic [AW-1:0]         new_start,
  input  wire logic [AW:0]           new_end,
  input  wire logic [1:0]            new_flags,
  input  wire logic                  prev_valid,
  input  wire logic [AW-1:0]         prev_start,
  input  wire logic [AW:0]           prev_end,
  input  wire logic [1:0]            prev_flags,
  input  wire logic                  next_valid,
  input  wire logic [AW-1:0]         next_start,
  input  wire logic [AW:0]           next_end,
  input  wire logic [1:0]            next_flags,
  input  wire logic [AW-1:0]         probe_lo,
  input  wire logic [AW:0]           probe_hi,
  input  wire logic                  gap_in,
  output logic                       valid,
  output logic [AW-1:0]              start,
  output logic [AW:0]                end_addr,
  output logic [1:0]                 flags,
  output logic                       hit,
  output logic                       less,
  output logic                       gap_out
);

  import mac_pkg::*;

  logic          valid_r;
  logic [AW-1:0] start_r;
  logic [AW:0]   end_r;
  logic [1:0]    flags_r;

  // Overlap-or-touch test against the probe range, and order test for insertion
  assign hit     = valid_r && ({1'b0, start_r} <= probe_hi) && (end_r >= {1'b0, probe_lo});
  assign less    = valid_r && (start_r < probe_lo);
  assign gap_out = gap_in || !valid_r;

  assign valid    = valid_r;
  assign start    = start_r;
  assign end_addr = end_r;
  assign flags    = flags_r;

  // Occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (op)
        CELL_HOLD: valid_r <= valid_r;
        CELL_LOAD: valid_r <= 1'b1;
        CELL_PREV: valid_r <= prev_valid;
        CELL_NEXT: valid_r <= next_valid;
        CELL_KILL: valid_r <= 1'b0;
        default:   valid_r <= valid_r;
      endcase
    end
  end

  // Range payload
  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD: begin
        start_r <= new_start;
        end_r   <= new_end;
        flags_r <= new_flags;
      end
      CELL_PREV: begin
        start_r <= prev_start;
        end_r   <= prev_end;
        flags_r <= prev_flags;
      end
      CELL_NEXT: begin
        start_r <= next_start;
        end_r   <= next_end;
        flags_r <= next_flags;
      end
      default: begin
        start_r <= start_r;
        end_r   <= end_r;
        flags_r <= flags_r;
      end
    endcase
  end

endmodule

`default_nettype wire
